### hdl/mmcd_pkg.sv
// ----------------------------------------------------------------------------
// mmcd_pkg
// Shared widths, register codes, reset values and types of the min/max
// column decimator.
// ----------------------------------------------------------------------------
`default_nettype none

package mmcd_pkg;

    localparam int N_BITS        = 24;
    localparam int W_BITS        = 13;
    localparam int COL_BITS      = 12;
    localparam int SAMPLE_BITS   = 16;
    localparam int MAX_COLUMNS   = 4096;
    localparam int SPREAD_SHIFT  = 5;
    localparam int SPREAD_BITS   = N_BITS + SPREAD_SHIFT;
    localparam int CFG_IDX_BITS  = 2;
    localparam int CFG_DATA_BITS = 24;
    localparam int QUEUE_DEPTH   = 4;
    localparam int QPTR_BITS     = $clog2(QUEUE_DEPTH);
    localparam int QCNT_BITS     = QPTR_BITS + 1;
    localparam int DIV_CNT_BITS  = $clog2(N_BITS + 1);

    localparam logic [N_BITS-1:0]   RESET_TOTAL = N_BITS'(1024);
    localparam logic [W_BITS-1:0]   RESET_COLS  = W_BITS'(512);
    localparam logic [N_BITS-1:0]   RESET_Q     = N_BITS'(1024 / 512);
    localparam logic [COL_BITS-1:0] RESET_R     = COL_BITS'(1024 % 512);

    typedef enum logic [CFG_IDX_BITS-1:0] {
        REG_TOTAL_SAMPLES = 2'd0,
        REG_COLUMN_COUNT  = 2'd1
    } t_cfg_reg;

    typedef enum logic [1:0] {
        DIV_IDLE,
        DIV_LOAD,
        DIV_RUN
    } t_div_state;

    typedef logic signed [SAMPLE_BITS-1:0] t_sample;

    typedef struct packed {
        logic                busy;
        logic                restart;
        logic [N_BITS-1:0]   step_q;
        logic [COL_BITS-1:0] step_r;
        logic [W_BITS-1:0]   eff_w;
        logic [N_BITS-1:0]   last_idx;
    } t_frame_cfg;

endpackage

`default_nettype wire

### hdl/mmcd_sample_if.sv
// ----------------------------------------------------------------------------
// mmcd_sample_if
// Valid/ready channel carrying one audio sample per transfer.
// ----------------------------------------------------------------------------
`default_nettype none

interface mmcd_sample_if;

    logic              valid;
    logic              ready;
    mmcd_pkg::t_sample sample;

    modport source (output valid, output sample, input ready);
    modport sink   (input valid, input sample, output ready);

endinterface

`default_nettype wire

### hdl/mmcd_result_if.sv
// ----------------------------------------------------------------------------
// mmcd_result_if
// Valid/ready channel carrying one column peak pair per transfer.
// ----------------------------------------------------------------------------
`default_nettype none

interface mmcd_result_if;

    logic                          valid;
    logic                          ready;
    logic [mmcd_pkg::COL_BITS-1:0] column;
    mmcd_pkg::t_sample             low_peak;
    mmcd_pkg::t_sample             high_peak;
    logic                          run_last;
    logic                          frame_last;

    modport source (
        output valid, output column, output low_peak, output high_peak,
        output run_last, output frame_last, input ready
    );
    modport sink (
        input valid, input column, input low_peak, input high_peak,
        input run_last, input frame_last, output ready
    );

endinterface

`default_nettype wire

### hdl/mmcd_cfg.sv
// ----------------------------------------------------------------------------
// mmcd_cfg
// Configuration registers, clamping of the column count and a bit-serial
// divider that produces the per-column step quotient and remainder.
// ----------------------------------------------------------------------------
`default_nettype none

module mmcd_cfg (
    input  wire logic                                i_clk,
    input  wire logic                                i_rst_n,
    input  wire logic                                i_cfg_we,
    input  wire logic [mmcd_pkg::CFG_IDX_BITS-1:0]   i_cfg_idx,
    input  wire logic [mmcd_pkg::CFG_DATA_BITS-1:0]  i_cfg_data,
    output      mmcd_pkg::t_frame_cfg                o_frame
);
    import mmcd_pkg::*;

    logic [N_BITS-1:0]       r_total, n_total;
    logic [W_BITS-1:0]       r_cols, n_cols;
    t_div_state              r_state, n_state;
    logic [DIV_CNT_BITS-1:0] r_cnt, n_cnt;
    logic [N_BITS-1:0]       r_quot, n_quot;
    logic [W_BITS-1:0]       r_rem, n_rem;
    logic [W_BITS-1:0]       r_eff_w, n_eff_w;
    logic [N_BITS-1:0]       r_last_idx, n_last_idx;
    logic [N_BITS-1:0]       r_step_q, n_step_q;
    logic [COL_BITS-1:0]     r_step_r, n_step_r;
    logic                    r_restart, n_restart;

    logic [N_BITS-1:0]      eff_n;
    logic [W_BITS-1:0]      w_nz, w_cap, eff_w;
    logic [SPREAD_BITS-1:0] spread;
    logic [W_BITS:0]        rem_sh;
    logic                   rem_ge;
    logic [W_BITS-1:0]      div_rem;
    logic [N_BITS-1:0]      div_quot;

    // effective frame size and column count
    always_comb begin
        eff_n  = (r_total == '0) ? N_BITS'(1) : r_total;
        w_nz   = (r_cols == '0) ? W_BITS'(1) : r_cols;
        w_cap  = (w_nz > W_BITS'(MAX_COLUMNS)) ? W_BITS'(MAX_COLUMNS) : w_nz;
        spread = {eff_n, SPREAD_SHIFT'(0)};
        eff_w  = (SPREAD_BITS'(w_cap) > spread) ? spread[W_BITS-1:0] : w_cap;
    end

    // one restoring divide step
    always_comb begin
        rem_sh   = {r_rem, r_quot[N_BITS-1]};
        rem_ge   = rem_sh >= {1'b0, r_eff_w};
        div_rem  = rem_ge ? W_BITS'(rem_sh - {1'b0, r_eff_w}) : rem_sh[W_BITS-1:0];
        div_quot = {r_quot[N_BITS-2:0], rem_ge};
    end

    always_comb begin
        n_total    = r_total;
        n_cols     = r_cols;
        n_state    = r_state;
        n_cnt      = r_cnt;
        n_quot     = r_quot;
        n_rem      = r_rem;
        n_eff_w    = r_eff_w;
        n_last_idx = r_last_idx;
        n_step_q   = r_step_q;
        n_step_r   = r_step_r;
        n_restart  = 1'b0;
        case (r_state)
            DIV_IDLE: ;
            DIV_LOAD: begin
                n_eff_w    = eff_w;
                n_last_idx = eff_n - 1'b1;
                n_quot     = eff_n;
                n_rem      = '0;
                n_cnt      = DIV_CNT_BITS'(N_BITS);
                n_state    = DIV_RUN;
            end
            DIV_RUN: begin
                n_quot = div_quot;
                n_rem  = div_rem;
                n_cnt  = r_cnt - 1'b1;
                if (r_cnt == DIV_CNT_BITS'(1)) begin
                    n_state   = DIV_IDLE;
                    n_step_q  = div_quot;
                    n_step_r  = div_rem[COL_BITS-1:0];
                    n_restart = 1'b1;
                end
            end
            default: n_state = DIV_IDLE;
        endcase
        if (i_cfg_we) begin
            case (i_cfg_idx)
                REG_TOTAL_SAMPLES: begin
                    n_total   = i_cfg_data[N_BITS-1:0];
                    n_state   = DIV_LOAD;
                    n_restart = 1'b0;
                end
                REG_COLUMN_COUNT: begin
                    n_cols    = i_cfg_data[W_BITS-1:0];
                    n_state   = DIV_LOAD;
                    n_restart = 1'b0;
                end
                default: ;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_total    <= RESET_TOTAL;
            r_cols     <= RESET_COLS;
            r_state    <= DIV_IDLE;
            r_cnt      <= '0;
            r_eff_w    <= RESET_COLS;
            r_last_idx <= RESET_TOTAL - 1'b1;
            r_step_q   <= RESET_Q;
            r_step_r   <= RESET_R;
            r_restart  <= 1'b0;
        end else begin
            r_total    <= n_total;
            r_cols     <= n_cols;
            r_state    <= n_state;
            r_cnt      <= n_cnt;
            r_eff_w    <= n_eff_w;
            r_last_idx <= n_last_idx;
            r_step_q   <= n_step_q;
            r_step_r   <= n_step_r;
            r_restart  <= n_restart;
        end
    end

    always_ff @(posedge i_clk) begin
        r_quot <= n_quot;
        r_rem  <= n_rem;
    end

    always_comb begin
        o_frame.busy     = (r_state != DIV_IDLE) || r_restart;
        o_frame.restart  = r_restart;
        o_frame.step_q   = r_step_q;
        o_frame.step_r   = r_step_r;
        o_frame.eff_w    = r_eff_w;
        o_frame.last_idx = r_last_idx;
    end

endmodule

`default_nettype wire

### hdl/mmcd_queue.sv
// ----------------------------------------------------------------------------
// mmcd_queue
// Front end: takes sample transfers into a short queue ahead of the column
// sequencer.
// ----------------------------------------------------------------------------
`default_nettype none

module mmcd_queue (
    input  wire logic                  i_clk,
    input  wire logic                  i_rst_n,
    mmcd_sample_if.sink                i_sample_ch,
    input  wire logic                  i_block,
    input  wire logic                  i_pop,
    output      logic                  o_head_valid,
    output      mmcd_pkg::t_sample     o_head
);
    import mmcd_pkg::*;

    t_sample              r_mem [QUEUE_DEPTH];
    logic [QPTR_BITS-1:0] r_wr, n_wr;
    logic [QPTR_BITS-1:0] r_rd, n_rd;
    logic [QCNT_BITS-1:0] r_count, n_count;
    logic                 push;

    assign i_sample_ch.ready = (r_count != QCNT_BITS'(QUEUE_DEPTH)) && !i_block;
    assign push              = i_sample_ch.valid && i_sample_ch.ready;
    assign o_head_valid      = r_count != '0;
    assign o_head            = r_mem[r_rd];

    always_comb begin
        n_wr    = push ? QPTR_BITS'(r_wr + 1'b1) : r_wr;
        n_rd    = i_pop ? QPTR_BITS'(r_rd + 1'b1) : r_rd;
        n_count = r_count + QCNT_BITS'(push) - QCNT_BITS'(i_pop);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr    <= '0;
            r_rd    <= '0;
            r_count <= '0;
        end else begin
            r_wr    <= n_wr;
            r_rd    <= n_rd;
            r_count <= n_count;
        end
    end

    always_ff @(posedge i_clk) begin
        if (push) begin
            r_mem[r_wr] <= i_sample_ch.sample;
        end
    end

endmodule

`default_nettype wire

### hdl/mmcd_back.sv
// ----------------------------------------------------------------------------
// mmcd_back
// Column sequencer: steps column bounds, tracks running peaks and emits one
// column result per cycle into the output register when it has room.
// ----------------------------------------------------------------------------
`default_nettype none

module mmcd_back (
    input  wire logic                  i_clk,
    input  wire logic                  i_rst_n,
    input  wire mmcd_pkg::t_frame_cfg  i_frame,
    input  wire logic                  i_head_valid,
    input  wire mmcd_pkg::t_sample     i_head,
    output      logic                  o_pop,
    mmcd_result_if.source              o_result_ch
);
    import mmcd_pkg::*;

    logic [COL_BITS-1:0] r_col, n_col;
    logic [N_BITS-1:0]   r_si, n_si;
    logic [N_BITS-1:0]   r_nb, n_nb;
    logic [COL_BITS-1:0] r_brem, n_brem;
    logic                r_nonempty, n_nonempty;
    t_sample             r_min, n_min;
    t_sample             r_max, n_max;

    logic                r_out_valid, n_out_valid;
    logic [COL_BITS-1:0] r_out_col, n_out_col;
    t_sample             r_out_low, n_out_low;
    t_sample             r_out_high, n_out_high;
    logic                r_out_run_last, n_out_run_last;
    logic                r_out_frame_last, n_out_frame_last;

    logic [W_BITS-1:0]   col_p1;
    logic [W_BITS:0]     col_p2;
    logic                loop_cond, loop_next, at_last;
    logic [W_BITS-1:0]   rem_sum;
    logic                carry;
    logic [N_BITS-1:0]   nb_next;
    logic [COL_BITS-1:0] brem_next;
    t_sample             a_min, a_max;
    logic                active, emit, out_free, go, pop;

    always_comb begin
        col_p1    = W_BITS'(r_col) + 1'b1;
        col_p2    = (W_BITS+1)'(r_col) + 2'd2;
        loop_cond = (col_p1 < i_frame.eff_w) && (r_nb == r_si);
        at_last   = r_si == i_frame.last_idx;
        rem_sum   = W_BITS'(r_brem) + W_BITS'(i_frame.step_r);
        carry     = rem_sum >= i_frame.eff_w;
        nb_next   = r_nb + i_frame.step_q + N_BITS'(carry);
        brem_next = carry ? COL_BITS'(rem_sum - i_frame.eff_w) : rem_sum[COL_BITS-1:0];
        loop_next = (col_p2 < {1'b0, i_frame.eff_w}) && (nb_next == r_si);
        a_min     = (!r_nonempty || (i_head < r_min)) ? i_head : r_min;
        a_max     = (!r_nonempty || (i_head > r_max)) ? i_head : r_max;
        active    = i_head_valid && !i_frame.busy;
        emit      = active && (loop_cond || at_last);
        out_free  = !r_out_valid || o_result_ch.ready;
        go        = active && (!emit || out_free);
        pop       = go && (loop_cond ? (!loop_next && !at_last) : 1'b1);
    end

    assign o_pop = pop;

    always_comb begin
        n_col      = r_col;
        n_si       = r_si;
        n_nb       = r_nb;
        n_brem     = r_brem;
        n_nonempty = r_nonempty;
        n_min      = r_min;
        n_max      = r_max;
        if (i_frame.restart) begin
            n_col      = '0;
            n_si       = '0;
            n_nb       = i_frame.step_q;
            n_brem     = i_frame.step_r;
            n_nonempty = 1'b0;
        end else if (go) begin
            if (loop_cond) begin
                n_col  = COL_BITS'(col_p1);
                n_nb   = nb_next;
                n_brem = brem_next;
                if (pop) begin
                    n_nonempty = 1'b1;
                    n_min      = i_head;
                    n_max      = i_head;
                    n_si       = r_si + 1'b1;
                end else begin
                    n_nonempty = 1'b0;
                end
            end else if (at_last) begin
                n_col      = '0;
                n_si       = '0;
                n_nb       = i_frame.step_q;
                n_brem     = i_frame.step_r;
                n_nonempty = 1'b0;
            end else begin
                n_nonempty = 1'b1;
                n_min      = a_min;
                n_max      = a_max;
                n_si       = r_si + 1'b1;
            end
        end
    end

    always_comb begin
        n_out_valid      = r_out_valid && !o_result_ch.ready;
        n_out_col        = r_out_col;
        n_out_low        = r_out_low;
        n_out_high       = r_out_high;
        n_out_run_last   = r_out_run_last;
        n_out_frame_last = r_out_frame_last;
        if (go && emit) begin
            n_out_valid      = 1'b1;
            n_out_col        = r_col;
            n_out_frame_last = col_p1 == i_frame.eff_w;
            if (loop_cond) begin
                n_out_low      = r_nonempty ? r_min : '0;
                n_out_high     = r_nonempty ? r_max : '0;
                n_out_run_last = !loop_next && !at_last;
            end else begin
                n_out_low      = a_min;
                n_out_high     = a_max;
                n_out_run_last = 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_col       <= '0;
            r_si        <= '0;
            r_nb        <= RESET_Q;
            r_brem      <= RESET_R;
            r_nonempty  <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            r_col       <= n_col;
            r_si        <= n_si;
            r_nb        <= n_nb;
            r_brem      <= n_brem;
            r_nonempty  <= n_nonempty;
            r_out_valid <= n_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_min            <= n_min;
        r_max            <= n_max;
        r_out_col        <= n_out_col;
        r_out_low        <= n_out_low;
        r_out_high       <= n_out_high;
        r_out_run_last   <= n_out_run_last;
        r_out_frame_last <= n_out_frame_last;
    end

    assign o_result_ch.valid      = r_out_valid;
    assign o_result_ch.column     = r_out_col;
    assign o_result_ch.low_peak   = r_out_low;
    assign o_result_ch.high_peak  = r_out_high;
    assign o_result_ch.run_last   = r_out_run_last;
    assign o_result_ch.frame_last = r_out_frame_last;

    a_no_pop_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_frame.busy |-> !pop)
        else $error("sample consumed during divide");

    a_col_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !i_frame.busy |-> (W_BITS'(r_col) < i_frame.eff_w))
        else $error("column index beyond column count");

    a_brem_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !i_frame.busy |-> (W_BITS'(r_brem) < i_frame.eff_w))
        else $error("boundary remainder not reduced");

    a_si_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !i_frame.busy |-> (r_si <= i_frame.last_idx))
        else $error("sample index past frame end");

    a_frame_wrap: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (go && !loop_cond && at_last) |=> (r_si == '0 && r_col == '0 && !r_nonempty))
        else $error("frame did not restart after last sample");

endmodule

`default_nettype wire

### hdl/min_max_column_decimator_top.sv
// ----------------------------------------------------------------------------
// Throughput: one sample per cycle while the queue has room and no divide
//   runs; a sample that closes k columns holds the sequencer while it emits
//   them (one result per cycle while the output is taken, at most 33 for one
//   sample). An accepted sample is stored in the queue, then the sequencer
//   puts its result in the output register. A register write runs a serial
//   divide; samples wait until it ends. Reset: 1024 samples, 512 columns.
// ----------------------------------------------------------------------------
// min_max_column_decimator_top
// Splits a sample stream into display columns and reports min/max per column.
// ----------------------------------------------------------------------------
`default_nettype none

module min_max_column_decimator_top (
    input  wire logic                                i_clk,
    input  wire logic                                i_rst_n,
    input  wire logic                                i_cfg_we,
    input  wire logic [mmcd_pkg::CFG_IDX_BITS-1:0]   i_cfg_idx,
    input  wire logic [mmcd_pkg::CFG_DATA_BITS-1:0]  i_cfg_data,
    mmcd_sample_if.sink                              i_sample_ch,
    mmcd_result_if.source                            o_result_ch
);
    import mmcd_pkg::*;

    t_frame_cfg frame;
    logic       head_valid;
    t_sample    head;
    logic       pop;

    mmcd_cfg u_cfg (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_cfg_we   (i_cfg_we),
        .i_cfg_idx  (i_cfg_idx),
        .i_cfg_data (i_cfg_data),
        .o_frame    (frame)
    );

    mmcd_queue u_queue (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_sample_ch  (i_sample_ch),
        .i_block      (frame.busy),
        .i_pop        (pop),
        .o_head_valid (head_valid),
        .o_head       (head)
    );

    mmcd_back u_back (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_frame      (frame),
        .i_head_valid (head_valid),
        .i_head       (head),
        .o_pop        (pop),
        .o_result_ch  (o_result_ch)
    );

endmodule

`default_nettype wire

### verif/tb.sv
// ----------------------------------------------------------------------------
// tb
// Self-checking bench for min_max_column_decimator_top. Streams samples over
// several frame and column settings, predicts every column min/max pair and
// compares each result transfer against the oldest prediction.
// ----------------------------------------------------------------------------
`default_nettype none

module tb;

    timeunit 1ns;
    timeprecision 1ps;

    import mmcd_pkg::*;

    localparam int SETTLE_CYCLES = 40;
    localparam int LONG_HOLD     = 300;
    localparam int CYCLE_LIMIT   = 400000;
    localparam int PHASE_ITEMS   = 15;

    localparam logic [CFG_IDX_BITS-1:0] CFG_SPARE_LO = 2'd2;
    localparam logic [CFG_IDX_BITS-1:0] CFG_SPARE_HI = 2'd3;

    typedef struct packed {
        logic [COL_BITS-1:0] column;
        t_sample             low_peak;
        t_sample             high_peak;
        logic                run_last;
        logic                frame_last;
    } t_column_peak;

    class column_peak_tracker;
        logic [N_BITS-1:0] total_reg;
        logic [W_BITS-1:0] columns_reg;
        logic [N_BITS-1:0] frame_len;
        logic [W_BITS-1:0] col_span;
        logic [N_BITS-1:0] step_q;
        logic [W_BITS-1:0] step_r;
        logic [W_BITS-1:0] col_idx;
        logic [N_BITS-1:0] smp_idx;
        logic [N_BITS-1:0] next_bnd;
        logic [W_BITS-1:0] bnd_rem;
        t_sample           lo_run;
        t_sample           hi_run;
        bit                has_sample;
        t_column_peak      expected_peaks[$];
        int                errors;

        function new();
            total_reg   = RESET_TOTAL;
            columns_reg = RESET_COLS;
            errors      = 0;
            restart();
        endfunction

        function void restart();
            int unsigned n;
            int unsigned w;
            n = total_reg;
            w = columns_reg;
            if (n == 0) n = 1;
            if (w == 0) w = 1;
            if (w > MAX_COLUMNS) w = MAX_COLUMNS;
            if (w > 32 * n) w = 32 * n;
            frame_len  = N_BITS'(n);
            col_span   = W_BITS'(w);
            step_q     = N_BITS'(n / w);
            step_r     = W_BITS'(n % w);
            next_bnd   = step_q;
            bnd_rem    = step_r;
            col_idx    = '0;
            smp_idx    = '0;
            lo_run     = '0;
            hi_run     = '0;
            has_sample = 1'b0;
        endfunction

        function void write_reg(logic [CFG_IDX_BITS-1:0] idx, logic [CFG_DATA_BITS-1:0] data);
            if (idx == REG_TOTAL_SAMPLES) begin
                total_reg = data[N_BITS-1:0];
                restart();
            end else if (idx == REG_COLUMN_COUNT) begin
                columns_reg = data[W_BITS-1:0];
                restart();
            end
        endfunction

        function void close_column();
            t_column_peak p;
            p.column     = col_idx[COL_BITS-1:0];
            p.low_peak   = has_sample ? lo_run : t_sample'(0);
            p.high_peak  = has_sample ? hi_run : t_sample'(0);
            p.run_last   = 1'b0;
            p.frame_last = (col_idx + 1'b1 == col_span);
            expected_peaks.push_back(p);
        endfunction

        function void take_sample(t_sample s);
            int first;
            first = expected_peaks.size();
            // columns ending at this sample index, empty ones included
            while (col_idx + 1'b1 < col_span && next_bnd == smp_idx) begin
                close_column();
                col_idx++;
                has_sample = 1'b0;
                next_bnd += step_q;
                bnd_rem  += step_r;
                if (bnd_rem >= col_span) begin
                    bnd_rem -= col_span;
                    next_bnd++;
                end
            end
            if (!has_sample) begin
                lo_run     = s;
                hi_run     = s;
                has_sample = 1'b1;
            end else begin
                if (s < lo_run) lo_run = s;
                if (s > hi_run) hi_run = s;
            end
            smp_idx++;
            if (smp_idx >= frame_len) begin
                close_column();
                restart();
            end
            if (expected_peaks.size() > first) expected_peaks[$].run_last = 1'b1;
        endfunction

        function int pending();
            return expected_peaks.size();
        endfunction

        function void check_field(string name, int want, int got);
            if (want != got) begin
                errors++;
                $display("%0t: %s expected %0d got %0d", $time, name, want, got);
            end
        endfunction

        function void check_column(t_column_peak got);
            t_column_peak want;
            if (expected_peaks.size() == 0) begin
                errors++;
                $display("%0t: column expected none got %0d (low %0d high %0d)",
                         $time, got.column, got.low_peak, got.high_peak);
                return;
            end
            want = expected_peaks.pop_front();
            check_field("column", want.column, got.column);
            check_field("low_peak", want.low_peak, got.low_peak);
            check_field("high_peak", want.high_peak, got.high_peak);
            check_field("run_last", want.run_last, got.run_last);
            check_field("frame_last", want.frame_last, got.frame_last);
        endfunction
    endclass

    logic                     i_clk;
    logic                     i_rst_n;
    logic                     i_cfg_we;
    logic [CFG_IDX_BITS-1:0]  i_cfg_idx;
    logic [CFG_DATA_BITS-1:0] i_cfg_data;

    mmcd_sample_if smp_ch ();
    mmcd_result_if res_ch ();

    min_max_column_decimator_top u_top (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_idx   (i_cfg_idx),
        .i_cfg_data  (i_cfg_data),
        .i_sample_ch (smp_ch),
        .o_result_ch (res_ch)
    );

    column_peak_tracker sb;

    int src_idle_pct;
    int rcv_idle_pct;
    int hold_seq;
    int hold_seen;
    int hold_left;
    int cycle_cnt;

    t_sample edge_samples [8] = '{
        16'sh8000, 16'sh7FFF, 16'sh0000, 16'shFFFF,
        16'sh0001, 16'sh5555, 16'shAAAA, 16'sh7FFE
    };

    initial i_clk = 1'b0;
    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    always @(posedge i_clk) begin
        cycle_cnt++;
        if (cycle_cnt > CYCLE_LIMIT) begin
            $display("Mismatches found");
            $finish;
        end
    end

    // result side: check transfers, random backpressure, long hold on request
    always @(posedge i_clk) begin : result_side
        t_column_peak seen;
        if (i_rst_n && res_ch.valid && res_ch.ready) begin
            seen.column     = res_ch.column;
            seen.low_peak   = res_ch.low_peak;
            seen.high_peak  = res_ch.high_peak;
            seen.run_last   = res_ch.run_last;
            seen.frame_last = res_ch.frame_last;
            sb.check_column(seen);
        end
        if (hold_seq != hold_seen) begin
            hold_seen = hold_seq;
            hold_left = LONG_HOLD;
        end
        if (hold_left > 0) begin
            hold_left--;
            res_ch.ready <= 1'b0;
        end else begin
            res_ch.ready <= ($urandom_range(0, 99) >= rcv_idle_pct);
        end
    end

    function automatic t_sample rand_sample();
        case ($urandom_range(0, 7))
            0:       return 16'sh8000;
            1:       return 16'sh7FFF;
            2:       return 16'sh0000;
            default: return t_sample'($urandom);
        endcase
    endfunction

    task automatic send_sample(input t_sample s);
        while ($urandom_range(0, 99) < src_idle_pct) begin
            smp_ch.valid <= 1'b0;
            @(posedge i_clk);
        end
        smp_ch.valid  <= 1'b1;
        smp_ch.sample <= s;
        @(posedge i_clk);
        while (!smp_ch.ready) @(posedge i_clk);
        sb.take_sample(s);
    endtask

    task automatic drain();
        smp_ch.valid <= 1'b0;
        while (sb.pending() != 0) @(posedge i_clk);
        repeat (SETTLE_CYCLES) @(posedge i_clk);
    endtask

    task automatic write_cfg(input logic [CFG_IDX_BITS-1:0] idx,
                             input logic [CFG_DATA_BITS-1:0] data);
        i_cfg_we   <= 1'b1;
        i_cfg_idx  <= idx;
        i_cfg_data <= data;
        @(posedge i_clk);
        sb.write_reg(idx, data);
    endtask

    task automatic set_frame(input logic [CFG_DATA_BITS-1:0] n,
                             input logic [CFG_DATA_BITS-1:0] w);
        drain();
        write_cfg(REG_TOTAL_SAMPLES, n);
        write_cfg(REG_COLUMN_COUNT, w);
        i_cfg_we <= 1'b0;
    endtask

    task automatic random_phase(input int items);
        logic [CFG_DATA_BITS-1:0] n;
        logic [CFG_DATA_BITS-1:0] w;
        case ($urandom_range(0, 9))
            0: begin
                n = CFG_DATA_BITS'($urandom_range(1, 4));
                w = CFG_DATA_BITS'($urandom_range(33, 8191));
            end
            1: begin
                n = CFG_DATA_BITS'($urandom_range(1, 24'hFFFFFF));
                w = CFG_DATA_BITS'($urandom_range(1, 8191));
            end
            2: begin
                n = $urandom_range(0, 1) ? 24'd0 : CFG_DATA_BITS'($urandom_range(1, 30));
                w = $urandom_range(0, 1) ? 24'd0 : CFG_DATA_BITS'($urandom_range(1, 40));
            end
            default: begin
                n = CFG_DATA_BITS'($urandom_range(1, 48));
                w = CFG_DATA_BITS'($urandom_range(1, 64));
            end
        endcase
        // bits above the column count field are ignored
        w = (CFG_DATA_BITS'($urandom) & 24'hFFE000) | w;
        set_frame(n, w);
        repeat (items) send_sample(rand_sample());
    endtask

    initial begin
        i_rst_n       <= 1'b0;
        i_cfg_we      <= 1'b0;
        i_cfg_idx     <= REG_TOTAL_SAMPLES;
        i_cfg_data    <= '0;
        smp_ch.valid  <= 1'b0;
        smp_ch.sample <= '0;
        hold_seq      = 0;
        src_idle_pct  = 12;
        rcv_idle_pct  = 85;
        sb = new();
        repeat (6) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // reset settings, two samples per column
        foreach (edge_samples[i]) send_sample(edge_samples[i]);
        // more columns than samples: empty columns
        set_frame(5, 13);
        repeat (5) send_sample(rand_sample());
        // zero frame length, column count clamped to 32 per sample
        set_frame(0, 8191);
        repeat (2) send_sample(rand_sample());
        // largest frame, most columns
        set_frame(24'hFFFFFF, CFG_DATA_BITS'(MAX_COLUMNS));
        repeat (3) send_sample(rand_sample());
        // zero column count
        set_frame(3, 0);
        repeat (3) send_sample(rand_sample());
        // writes to unused indexes must leave the open frame alone
        set_frame(7, 3);
        repeat (3) send_sample(rand_sample());
        drain();
        write_cfg(CFG_SPARE_LO, 24'hFFFFFF);
        write_cfg(CFG_SPARE_HI, 24'h000000);
        i_cfg_we <= 1'b0;
        repeat (3) send_sample(rand_sample());

        for (int part = 0; part < 3; part++) begin
            case (part)
                0: begin
                    src_idle_pct = 12;
                    rcv_idle_pct = 85;
                end
                1: begin
                    src_idle_pct = 85;
                    rcv_idle_pct = 12;
                end
                default: begin
                    src_idle_pct = 0;
                    rcv_idle_pct = 0;
                end
            endcase
            for (int ph = 0; ph < 3; ph++) random_phase(PHASE_ITEMS);
            if (part == 1) begin
                repeat (10) send_sample(rand_sample());
                drain();
                repeat (10) send_sample(rand_sample());
            end
            if (part == 2) begin
                set_frame(2, 8);
                hold_seq <= hold_seq + 1;
                repeat (40) send_sample(rand_sample());
            end
        end

        drain();
        if (sb.errors == 0) begin
            $display("No mismatches found");
        end else begin
            $display("Mismatches found");
        end
        $finish;
    end

endmodule

`default_nettype wire
